>>> sv/figure_eight_setpoint_generator_top_assert.svh
// Assertion macros for the figure-eight setpoint generator.
// Included by the top level; needs no package.
`ifndef FIGURE_EIGHT_SETPOINT_GENERATOR_TOP_ASSERT_SVH
`define FIGURE_EIGHT_SETPOINT_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define FESG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fesg assertion failed");
// Next-cycle implication.
`define FESG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fesg assertion failed");
`else
`define FESG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FESG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/fesg_pkg.sv
// Types, constants and arithmetic helpers of the figure-eight setpoint generator.
// No dependencies.
package fesg_pkg;

    // Datapath widths
    localparam int CW     = 36;   // CORDIC x, y, z
    localparam int MUL_AW = 40;
    localparam int MUL_BW = 32;
    localparam int PW     = 72;   // product and wide sums
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 25;
    localparam int CORDIC_ITERS = 30;

    // Arithmetic constants
    localparam logic signed [CW-1:0] CORDIC_K    = 36'sd652032874;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic [39:0]          RATE_NUM    = 40'd1054143570000;
    localparam logic [21:0]          PERIOD_MIN  = 22'd10000;
    localparam logic signed [20:0]   YAW_SENTINEL = 21'sd666666;

    // Item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    // Register indexes
    localparam logic [CFG_AW-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_AW-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_AW-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [CFG_AW-1:0] REG_PERIOD   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_AXIS     = 3'd4;
    localparam logic [CFG_AW-1:0] REG_YAW_EN   = 3'd5;
    localparam logic [CFG_AW-1:0] REG_BYPASS   = 3'd6;

    // Divider passes
    localparam logic [1:0] DV_MOD  = 2'd0;
    localparam logic [1:0] DV_TURN = 2'd1;
    localparam logic [1:0] DV_RATE = 2'd2;

    // Multiplier program steps
    localparam logic [3:0] MS_Z1   = 4'd0;
    localparam logic [3:0] MS_Z2   = 4'd1;
    localparam logic [3:0] MS_VW   = 4'd2;
    localparam logic [3:0] MS_VN   = 4'd3;
    localparam logic [3:0] MS_AW1  = 4'd4;
    localparam logic [3:0] MS_AN1  = 4'd5;
    localparam logic [3:0] MS_AW2  = 4'd6;
    localparam logic [3:0] MS_AN2  = 4'd7;
    localparam logic [3:0] MS_VWF  = 4'd8;
    localparam logic [3:0] MS_VNF  = 4'd9;
    localparam logic [3:0] MS_AWF  = 4'd10;
    localparam logic [3:0] MS_ANF  = 4'd11;
    localparam logic [3:0] MS_PW   = 4'd12;
    localparam logic [3:0] MS_PN   = 4'd13;
    localparam logic [3:0] MS_YAW  = 4'd14;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIV   = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_MULW  = 9'b000001000,
        S_ROT   = 9'b000010000,
        S_ROTW  = 9'b000100000,
        S_VINIT = 9'b001000000,
        S_VEC   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    // Arctangent table, Q30 radians
    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CW-1:0] v;
        case (idx)
            5'd0:  v = 36'sd843314856;
            5'd1:  v = 36'sd497837829;
            5'd2:  v = 36'sd263043836;
            5'd3:  v = 36'sd133525158;
            5'd4:  v = 36'sd67021686;
            5'd5:  v = 36'sd33543515;
            5'd6:  v = 36'sd16775850;
            5'd7:  v = 36'sd8388437;
            5'd8:  v = 36'sd4194282;
            5'd9:  v = 36'sd2097149;
            5'd10: v = 36'sd1048575;
            5'd11: v = 36'sd524287;
            5'd12: v = 36'sd262143;
            5'd13: v = 36'sd131071;
            5'd14: v = 36'sd65535;
            5'd15: v = 36'sd32767;
            5'd16: v = 36'sd16383;
            5'd17: v = 36'sd8191;
            5'd18: v = 36'sd4095;
            5'd19: v = 36'sd2047;
            5'd20: v = 36'sd1023;
            5'd21: v = 36'sd511;
            5'd22: v = 36'sd255;
            5'd23: v = 36'sd127;
            5'd24: v = 36'sd63;
            5'd25: v = 36'sd31;
            5'd26: v = 36'sd15;
            5'd27: v = 36'sd8;
            5'd28: v = 36'sd4;
            5'd29: v = 36'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Shift right, rounding toward zero
    function automatic logic signed [PW-1:0] trunc_shift(input logic signed [PW-1:0] v,
                                                         input int unsigned s);
        logic signed [PW-1:0] bias;
        bias = (72'sd1 <<< s) - 72'sd1;
        return v[PW-1] ? ((v + bias) >>> s) : (v >>> s);
    endfunction

    // Clamp to a signed field of the given width
    function automatic logic signed [PW-1:0] sat(input logic signed [PW-1:0] v,
                                                 input int unsigned bits);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        hi = (72'sd1 <<< (bits - 1)) - 72'sd1;
        lo = -hi - 72'sd1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

endpackage

>>> sv/figure_eight_setpoint_generator_top.sv
// Figure-eight setpoint generator: sequencer, divider, CORDIC and multiplier.
// Depends on fesg_pkg and figure_eight_setpoint_generator_top_assert.svh.
`include "figure_eight_setpoint_generator_top_assert.svh"

// Start, stop and unproductive ticks are handled without leaving the idle
// state. A tick that yields a setpoint runs three bit-serial divisions for
// phase residue, turn fraction and angular rate, two 30-step CORDIC
// rotations and a 30-step CORDIC vectoring pass in one shared CORDIC unit,
// and 15 products in one shared multiplier. While busy the input is
// stalled; a finished setpoint waits in the output register while the next
// item is taken.
module figure_eight_setpoint_generator_top #(
    parameter int TICK_TIME_UNITS = 200
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fesg_pkg::CFG_AW-1:0]    cfg_index,
    input  logic [fesg_pkg::CFG_DW-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     kind,
    input  logic                           authority_ok,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [24:0]             pos_x,
    output logic signed [24:0]             pos_y,
    output logic signed [24:0]             pos_z,
    output logic signed [20:0]             heading,
    output logic signed [17:0]             vel_x,
    output logic signed [17:0]             vel_y,
    output logic signed [21:0]             acc_x,
    output logic signed [21:0]             acc_y
);
    import fesg_pkg::*;

    // Configuration
    logic signed [24:0] center_x_reg, center_y_reg, center_z_reg;
    logic [21:0]        period_reg;
    logic               axis_mode_reg, yaw_enable_reg, bypass_reg;

    // Control
    state_t             state_reg, state_next;
    logic               armed_reg;
    logic [21:0]        residue_reg;
    logic [21:0]        p_eff;
    logic               in_acc, auth;

    // Divider
    logic [21:0]        rem_reg;
    logic [39:0]        num_reg;
    logic [31:0]        quo_reg;
    logic [5:0]         cnt_reg;
    logic [1:0]         div_sel_reg;
    logic [22:0]        div_t;
    logic               div_ge, div_last;
    logic [21:0]        div_rem;
    logic [31:0]        div_quo;
    logic [21:0]        r_reg;
    logic [31:0]        u_reg;
    logic signed [27:0] om_reg;

    // CORDIC
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic [4:0]           iter_reg;
    logic [1:0]           quad_reg;
    logic                 rot_sel_reg, zero_reg;
    logic signed [CW-1:0] dx, dy, at;
    logic                 cpos, iter_last;
    logic signed [CW-1:0] vx_in, vy_in;
    logic signed [CW-1:0] s1_reg, c1_reg, s2_reg, c2_reg;
    logic signed [CW-1:0] sn_q, cs_q, yaw_val;

    // Multiplier
    logic [3:0]               step_reg;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [PW-1:0]     mul_p, prod_reg, tr24, tr30;
    logic signed [39:0]       tv1_reg, tv2_reg, ta1_reg, ta2_reg;
    logic signed [25:0]       wv_reg, nv_reg, wa_reg, na_reg, hd_reg;
    logic signed [47:0]       wpos_reg, npos_reg;

    // Output
    logic               out_valid_reg, out_free;
    logic signed [24:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [20:0] heading_reg;
    logic signed [17:0] vel_x_reg, vel_y_reg;
    logic signed [21:0] acc_x_reg, acc_y_reg;
    logic signed [PW-1:0] sum_x, sum_y;
    logic [22:0]        res_sum;
    logic [21:0]        res_adv;

    assign p_eff    = (period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg;
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign auth     = authority_ok || bypass_reg;
    assign out_free = !out_valid_reg || !out_stall;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            center_z_reg   <= '0;
            period_reg     <= 22'd100000;
            axis_mode_reg  <= 1'b0;
            yaw_enable_reg <= 1'b0;
            bypass_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X: center_x_reg   <= $signed(cfg_data);
                REG_CENTER_Y: center_y_reg   <= $signed(cfg_data);
                REG_CENTER_Z: center_z_reg   <= $signed(cfg_data);
                REG_PERIOD:   period_reg     <= cfg_data[21:0];
                REG_AXIS:     axis_mode_reg  <= cfg_data[0];
                REG_YAW_EN:   yaw_enable_reg <= cfg_data[0];
                REG_BYPASS:   bypass_reg     <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Sequence the shared units
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_acc && kind == KIND_TICK && auth && armed_reg)
                    state_next = S_DIV;
            S_DIV:
                if (div_last && div_sel_reg == DV_RATE)
                    state_next = S_MUL;
            S_MUL:
                state_next = S_MULW;
            S_MULW:
                if (step_reg == MS_Z1 || step_reg == MS_Z2)
                    state_next = S_ROT;
                else if (step_reg == MS_YAW)
                    state_next = S_OUT;
                else
                    state_next = S_MUL;
            S_ROT:
                if (iter_last)
                    state_next = S_ROTW;
            S_ROTW:
                state_next = rot_sel_reg ? S_VINIT : S_MUL;
            S_VINIT:
                state_next = S_VEC;
            S_VEC:
                if (iter_last)
                    state_next = S_MUL;
            S_OUT:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold arming and phase
    assign res_sum = {1'b0, r_reg} + 23'(TICK_TIME_UNITS);
    assign res_adv = (res_sum >= {1'b0, p_eff}) ? 22'(res_sum - {1'b0, p_eff})
                                                : res_sum[21:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            armed_reg   <= 1'b0;
            residue_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && in_acc)
            begin
                case (kind)
                    KIND_START:
                    begin
                        armed_reg   <= 1'b1;
                        residue_reg <= '0;
                    end
                    KIND_STOP:
                    begin
                        armed_reg   <= 1'b0;
                        residue_reg <= '0;
                    end
                    KIND_TICK:
                        if (!(auth && armed_reg))
                        begin
                            armed_reg   <= 1'b0;
                            residue_reg <= '0;
                        end
                    default: ;
                endcase
            end
            else if (state_reg == S_OUT && out_free)
                residue_reg <= res_adv;
        end
    end

    // Restoring divider, one quotient bit per cycle
    assign div_t    = {rem_reg, num_reg[39]};
    assign div_ge   = (div_t >= {1'b0, p_eff});
    assign div_rem  = div_ge ? 22'(div_t - {1'b0, p_eff}) : div_t[21:0];
    assign div_quo  = {quo_reg[30:0], div_ge};
    assign div_last = (cnt_reg == 6'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            div_sel_reg <= DV_MOD;
        end
        else if (state_reg == S_IDLE)
        begin
            cnt_reg     <= 6'd22;
            div_sel_reg <= DV_MOD;
        end
        else if (state_reg == S_DIV && div_last)
        begin
            case (div_sel_reg)
                DV_MOD:
                begin
                    cnt_reg     <= 6'd32;
                    div_sel_reg <= DV_TURN;
                end
                DV_TURN:
                begin
                    cnt_reg     <= 6'd40;
                    div_sel_reg <= DV_RATE;
                end
                default: ;
            endcase
        end
        else if (state_reg == S_DIV)
            cnt_reg <= cnt_reg - 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            rem_reg <= '0;
            num_reg <= {residue_reg, 18'b0};
            quo_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            if (div_last)
            begin
                case (div_sel_reg)
                    DV_MOD:
                    begin
                        r_reg   <= div_rem;
                        rem_reg <= div_rem;
                        num_reg <= '0;
                        quo_reg <= '0;
                    end
                    DV_TURN:
                    begin
                        u_reg   <= div_quo;
                        rem_reg <= '0;
                        num_reg <= RATE_NUM;
                        quo_reg <= '0;
                    end
                    default:
                        om_reg <= $signed({1'b0, div_quo[26:0]});
                endcase
            end
            else
            begin
                rem_reg <= div_rem;
                num_reg <= {num_reg[38:0], 1'b0};
                quo_reg <= div_quo;
            end
        end
    end

    // CORDIC micro-rotation, shared by rotation and vectoring
    assign dx        = y_reg >>> iter_reg;
    assign dy        = x_reg >>> iter_reg;
    assign at        = atan_q30(iter_reg);
    assign cpos      = (state_reg == S_ROT) ? !z_reg[CW-1] : !(y_reg > 36'sd0);
    assign iter_last = (iter_reg == 5'(CORDIC_ITERS - 1));
    assign vx_in     = axis_mode_reg ? -c2_reg : c1_reg;
    assign vy_in     = axis_mode_reg ? c1_reg : -c2_reg;
    assign yaw_val   = zero_reg ? '0 : z_reg;

    // Restore the quadrant of the rotated pair
    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                sn_q = y_reg;
                cs_q = x_reg;
            end
            2'd1:
            begin
                sn_q = x_reg;
                cs_q = -y_reg;
            end
            2'd2:
            begin
                sn_q = -y_reg;
                cs_q = -x_reg;
            end
            default:
            begin
                sn_q = -x_reg;
                cs_q = y_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_MULW:
                if (step_reg == MS_Z1 || step_reg == MS_Z2)
                begin
                    x_reg       <= CORDIC_K;
                    y_reg       <= '0;
                    z_reg       <= CW'(prod_reg >>> 30);
                    iter_reg    <= '0;
                    rot_sel_reg <= (step_reg == MS_Z2);
                    quad_reg    <= (step_reg == MS_Z2) ? u_reg[30:29] : u_reg[31:30];
                end
            S_ROT, S_VEC:
            begin
                x_reg    <= cpos ? (x_reg - dx) : (x_reg + dx);
                y_reg    <= cpos ? (y_reg + dy) : (y_reg - dy);
                z_reg    <= cpos ? (z_reg - at) : (z_reg + at);
                iter_reg <= iter_reg + 5'd1;
            end
            S_ROTW:
                if (rot_sel_reg)
                begin
                    s2_reg <= sn_q;
                    c2_reg <= cs_q;
                end
                else
                begin
                    s1_reg <= sn_q;
                    c1_reg <= cs_q;
                end
            S_VINIT:
            begin
                iter_reg <= '0;
                zero_reg <= (vx_in == '0) && (vy_in == '0);
                if (vx_in < 0 && vy_in >= 0)
                begin
                    x_reg <= vy_in;
                    y_reg <= -vx_in;
                    z_reg <= HALF_PI_Q30;
                end
                else if (vx_in < 0)
                begin
                    x_reg <= -vy_in;
                    y_reg <= vx_in;
                    z_reg <= -HALF_PI_Q30;
                end
                else
                begin
                    x_reg <= vx_in;
                    y_reg <= vy_in;
                    z_reg <= '0;
                end
            end
            default: ;
        endcase
    end

    // Select multiplier operands for the current step
    always_comb
    begin
        case (step_reg)
            MS_Z1:   mul_a = $signed({10'b0, u_reg[29:0]});
            MS_Z2:   mul_a = $signed({10'b0, u_reg[28:0], 1'b0});
            MS_VW:   mul_a = 40'(c1_reg);
            MS_VN:   mul_a = 40'(c2_reg);
            MS_AW1:  mul_a = 40'(s1_reg);
            MS_AN1:  mul_a = 40'(s2_reg);
            MS_AW2:  mul_a = ta1_reg;
            MS_AN2:  mul_a = ta2_reg;
            MS_VWF:  mul_a = tv1_reg;
            MS_VNF:  mul_a = tv2_reg;
            MS_AWF:  mul_a = ta1_reg;
            MS_ANF:  mul_a = ta2_reg;
            MS_PW:   mul_a = 40'(s1_reg);
            MS_PN:   mul_a = 40'(s2_reg);
            default: mul_a = 40'(yaw_val);
        endcase
        case (step_reg)
            MS_Z1, MS_Z2:  mul_b = 32'(HALF_PI_Q30);
            MS_VWF, MS_PW: mul_b = 32'sd20000;
            MS_VNF:        mul_b = 32'sd20000;
            MS_AWF:        mul_b = -32'sd20000;
            MS_ANF:        mul_b = -32'sd40000;
            MS_PN, MS_YAW: mul_b = 32'sd10000;
            default:       mul_b = 32'(om_reg);
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign tr24  = trunc_shift(prod_reg, 24);
    assign tr30  = trunc_shift(prod_reg, 30);

    // Register the product, then store it where the step sends it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= MS_Z1;
        else if (state_reg == S_IDLE)
            step_reg <= MS_Z1;
        else if (state_reg == S_MULW)
            step_reg <= step_reg + 4'd1;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
            prod_reg <= mul_p;
        else if (state_reg == S_MULW)
        begin
            case (step_reg)
                MS_VW:   tv1_reg  <= 40'(tr24);
                MS_VN:   tv2_reg  <= 40'(tr24);
                MS_AW1:  ta1_reg  <= 40'(tr24);
                MS_AN1:  ta2_reg  <= 40'(tr24);
                MS_AW2:  ta1_reg  <= 40'(tr24);
                MS_AN2:  ta2_reg  <= 40'(tr24);
                MS_VWF:  wv_reg   <= 26'(tr30);
                MS_VNF:  nv_reg   <= 26'(tr30);
                MS_AWF:  wa_reg   <= 26'(tr30);
                MS_ANF:  na_reg   <= 26'(tr30);
                MS_PW:   wpos_reg <= 48'(prod_reg);
                MS_PN:   npos_reg <= 48'(prod_reg);
                MS_YAW:  hd_reg   <= 26'(tr30);
                default: ;
            endcase
        end
    end

    // Add the center and drop the fraction
    assign sum_x = $signed({{17{center_x_reg[24]}}, center_x_reg, 30'b0})
                 + (axis_mode_reg ? 72'(npos_reg) : 72'(wpos_reg));
    assign sum_y = $signed({{17{center_y_reg[24]}}, center_y_reg, 30'b0})
                 + (axis_mode_reg ? 72'(wpos_reg) : 72'(npos_reg));

    // Load the output register and hold it until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            pos_x_reg   <= 25'(sat(trunc_shift(sum_x, 30), 25));
            pos_y_reg   <= 25'(sat(trunc_shift(sum_y, 30), 25));
            pos_z_reg   <= center_z_reg;
            heading_reg <= yaw_enable_reg ? 21'(sat(72'(hd_reg), 21)) : YAW_SENTINEL;
            vel_x_reg   <= 18'(sat(72'(axis_mode_reg ? nv_reg : wv_reg), 18));
            vel_y_reg   <= 18'(sat(72'(axis_mode_reg ? wv_reg : nv_reg), 18));
            acc_x_reg   <= 22'(sat(72'(axis_mode_reg ? na_reg : wa_reg), 22));
            acc_y_reg   <= 22'(sat(72'(axis_mode_reg ? wa_reg : na_reg), 22));
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign heading   = heading_reg;
    assign vel_x     = vel_x_reg;
    assign vel_y     = vel_y_reg;
    assign acc_x     = acc_x_reg;
    assign acc_y     = acc_y_reg;

    // Control items and ignored ticks finish in the cycle they are taken
    `FESG_ASSERT_NXT(a_ctrl_stays_idle, clk, rst_n, in_acc && kind != KIND_TICK, state_reg == S_IDLE)
    // A new setpoint leaves the phase inside the period
    `FESG_ASSERT_IMP(a_residue_in_period, clk, rst_n, $rose(out_valid), residue_reg < p_eff)
    // A finished setpoint lands in the output register and frees the block
    `FESG_ASSERT_NXT(a_out_load, clk, rst_n, state_reg == S_OUT && out_free, out_valid_reg && state_reg == S_IDLE)

endmodule
